// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker module of the vertex transform unit.
// Standalone header; it has no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define VTP_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define VTP_ASSERT_RAW(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== hdl/vtp_pkg.sv =====
// Types, constants and helper functions of the vertex transform and projection unit.
// Used by every module of the unit; it depends on nothing else.
package vtp_pkg;

  localparam int COORD_BITS     = 16;
  localparam int TRIG_BITS      = 16;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int MODE_BITS      = 3;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = (COORD_BITS > TRIG_BITS) ? COORD_BITS : TRIG_BITS;
  localparam int OPND_BITS      = COORD_BITS + 1;
  localparam int PROD_BITS      = OPND_BITS + CFG_DATA_BITS;
  localparam int SUM_BITS       = PROD_BITS + 1;
  localparam int STAGES         = 5;

  localparam logic [MODE_BITS-1:0] MODE_TRANSLATE = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_SCALE     = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_ROT_X     = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_ROT_Y     = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_ROT_Z     = 3'd4;

  localparam logic [CFG_IDX_BITS-1:0] REG_OP_MODE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_VEC_X   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_VEC_Y   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_VEC_Z   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_COS     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIN     = 3'd5;

  typedef logic signed [COORD_BITS-1:0]    coord_t;
  typedef logic signed [TRIG_BITS-1:0]     trig_t;
  typedef logic signed [CFG_DATA_BITS-1:0] coef_t;
  typedef logic signed [OPND_BITS-1:0]     opnd_t;
  typedef logic signed [PROD_BITS-1:0]     prod_t;
  typedef logic signed [SUM_BITS-1:0]      sum_t;

  localparam trig_t COS_RESET  = trig_t'(2 ** TRIG_FRAC_BITS);
  localparam sum_t  TRUNC_BIAS = sum_t'(2 ** TRIG_FRAC_BITS - 1);
  localparam sum_t  SUM_ZERO   = sum_t'(0);
  localparam sum_t  SAT_HI     = sum_t'(2 ** (COORD_BITS - 1) - 1);
  localparam sum_t  SAT_LO     = ~SAT_HI;

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t pz;
  } vtp_in_t;

  typedef struct packed {
    coord_t tx_out;
    coord_t ty_out;
    coord_t tz_out;
    coord_t screen_x;
    coord_t screen_y;
    logic   saturated;
  } vtp_out_t;

  typedef struct packed {
    logic [MODE_BITS-1:0] op_mode;
    coord_t               vec_x;
    coord_t               vec_y;
    coord_t               vec_z;
    trig_t                cos_q14;
    trig_t                sin_q14;
  } vtp_cfg_t;

  typedef struct packed {
    opnd_t ax;
    opnd_t ay;
    opnd_t az;
    prod_t x0;
    prod_t x1;
    prod_t y0;
    prod_t y1;
    prod_t z0;
    prod_t z1;
  } vtp_prod_t;

  typedef struct packed {
    coord_t tx;
    coord_t ty;
    coord_t tz;
    logic   sat;
  } vtp_xfm_t;

  typedef struct packed {
    logic   sat;
    coord_t val;
  } vtp_clamp_t;

  function automatic vtp_clamp_t clamp_coord(input sum_t v);
    vtp_clamp_t r;
    r.sat = 1'b1;
    if (v > SAT_HI) begin
      r.val = SAT_HI[COORD_BITS-1:0];
    end else if (v < SAT_LO) begin
      r.val = SAT_LO[COORD_BITS-1:0];
    end else begin
      r.sat = 1'b0;
      r.val = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/vtp_cfg.sv =====
// Configuration register file of the vertex transform unit.
// Depends on vtp_pkg for the register indexes and the register struct.
module vtp_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [vtp_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [vtp_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output vtp_pkg::vtp_cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.op_mode <= vtp_pkg::MODE_TRANSLATE;
      cfg.vec_x   <= '0;
      cfg.vec_y   <= '0;
      cfg.vec_z   <= '0;
      cfg.cos_q14 <= vtp_pkg::COS_RESET;
      cfg.sin_q14 <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        vtp_pkg::REG_OP_MODE: cfg.op_mode <= cfg_data[vtp_pkg::MODE_BITS-1:0];
        vtp_pkg::REG_VEC_X:   cfg.vec_x   <= cfg_data[vtp_pkg::COORD_BITS-1:0];
        vtp_pkg::REG_VEC_Y:   cfg.vec_y   <= cfg_data[vtp_pkg::COORD_BITS-1:0];
        vtp_pkg::REG_VEC_Z:   cfg.vec_z   <= cfg_data[vtp_pkg::COORD_BITS-1:0];
        vtp_pkg::REG_COS:     cfg.cos_q14 <= cfg_data[vtp_pkg::TRIG_BITS-1:0];
        vtp_pkg::REG_SIN:     cfg.sin_q14 <= cfg_data[vtp_pkg::TRIG_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/vtp_front.sv =====
// Front stages: operand preparation (offset or translation) and the product stage.
// Depends on vtp_pkg for the configuration, vertex and product types.
module vtp_front (
  input  logic               clk,
  input  logic [1:0]         adv,
  input  vtp_pkg::vtp_cfg_t  cfg,
  input  vtp_pkg::vtp_in_t   vertex,
  output vtp_pkg::vtp_prod_t prod
);

  vtp_pkg::opnd_t ax, ay, az;
  vtp_pkg::opnd_t ax_next, ay_next, az_next;
  vtp_pkg::opnd_t bx, by, bz;
  vtp_pkg::coef_t kx, ky, kz, ks;
  logic           is_rot;

  always_comb begin
    is_rot = cfg.op_mode inside {vtp_pkg::MODE_ROT_X, vtp_pkg::MODE_ROT_Y,
                                 vtp_pkg::MODE_ROT_Z};
    if (cfg.op_mode == vtp_pkg::MODE_TRANSLATE) begin
      ax_next = vtp_pkg::opnd_t'(vertex.px) + vtp_pkg::opnd_t'(cfg.vec_x);
      ay_next = vtp_pkg::opnd_t'(vertex.py) + vtp_pkg::opnd_t'(cfg.vec_y);
      az_next = vtp_pkg::opnd_t'(vertex.pz) + vtp_pkg::opnd_t'(cfg.vec_z);
    end else if (is_rot) begin
      ax_next = vtp_pkg::opnd_t'(vertex.px) - vtp_pkg::opnd_t'(cfg.vec_x);
      ay_next = vtp_pkg::opnd_t'(vertex.py) - vtp_pkg::opnd_t'(cfg.vec_y);
      az_next = vtp_pkg::opnd_t'(vertex.pz) - vtp_pkg::opnd_t'(cfg.vec_z);
    end else begin
      ax_next = vtp_pkg::opnd_t'(vertex.px);
      ay_next = vtp_pkg::opnd_t'(vertex.py);
      az_next = vtp_pkg::opnd_t'(vertex.pz);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ax <= ax_next;
      ay <= ay_next;
      az <= az_next;
    end
  end

  // The first product of each axis takes the scale factor or the cosine, the
  // second one always takes the sine.
  always_comb begin
    if (cfg.op_mode == vtp_pkg::MODE_SCALE) begin
      kx = vtp_pkg::coef_t'(cfg.vec_x);
      ky = vtp_pkg::coef_t'(cfg.vec_y);
      kz = vtp_pkg::coef_t'(cfg.vec_z);
    end else begin
      kx = vtp_pkg::coef_t'(cfg.cos_q14);
      ky = vtp_pkg::coef_t'(cfg.cos_q14);
      kz = vtp_pkg::coef_t'(cfg.cos_q14);
    end
    ks = vtp_pkg::coef_t'(cfg.sin_q14);
    bx = (cfg.op_mode == vtp_pkg::MODE_ROT_Y) ? az : ay;
    by = (cfg.op_mode == vtp_pkg::MODE_ROT_X) ? az : ax;
    bz = (cfg.op_mode == vtp_pkg::MODE_ROT_X) ? ay : ax;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      prod.ax <= ax;
      prod.ay <= ay;
      prod.az <= az;
      prod.x0 <= vtp_pkg::prod_t'(ax) * vtp_pkg::prod_t'(kx);
      prod.x1 <= vtp_pkg::prod_t'(bx) * vtp_pkg::prod_t'(ks);
      prod.y0 <= vtp_pkg::prod_t'(ay) * vtp_pkg::prod_t'(ky);
      prod.y1 <= vtp_pkg::prod_t'(by) * vtp_pkg::prod_t'(ks);
      prod.z0 <= vtp_pkg::prod_t'(az) * vtp_pkg::prod_t'(kz);
      prod.z1 <= vtp_pkg::prod_t'(bz) * vtp_pkg::prod_t'(ks);
    end
  end

endmodule

// ===== hdl/vtp_back.sv =====
// Back stages: product sums with truncating fixed-point scaling, then pivot
// restore and saturation of the transformed vertex. Depends on vtp_pkg.
module vtp_back (
  input  logic               clk,
  input  logic [1:0]         adv,
  input  vtp_pkg::vtp_cfg_t  cfg,
  input  vtp_pkg::vtp_prod_t prod,
  output vtp_pkg::vtp_xfm_t  xfm
);

  function automatic vtp_pkg::sum_t div_trunc(input vtp_pkg::sum_t v);
    vtp_pkg::sum_t bias;
    vtp_pkg::sum_t t;
    bias = v[vtp_pkg::SUM_BITS-1] ? vtp_pkg::TRUNC_BIAS : vtp_pkg::SUM_ZERO;
    t    = v + bias;
    return t >>> vtp_pkg::TRIG_FRAC_BITS;
  endfunction

  vtp_pkg::sum_t      sx, sy, sz;
  vtp_pkg::sum_t      vx_next, vy_next, vz_next;
  vtp_pkg::sum_t      vx, vy, vz;
  vtp_pkg::sum_t      fx, fy, fz;
  vtp_pkg::vtp_clamp_t cx, cy, cz;
  logic               is_rot;

  always_comb begin
    sx = vtp_pkg::sum_t'(prod.x0);
    sy = vtp_pkg::sum_t'(prod.y0);
    sz = vtp_pkg::sum_t'(prod.z0);
    if (cfg.op_mode == vtp_pkg::MODE_ROT_Z) begin
      sx = sx - vtp_pkg::sum_t'(prod.x1);
    end else begin
      sx = sx + vtp_pkg::sum_t'(prod.x1);
    end
    if (cfg.op_mode == vtp_pkg::MODE_ROT_X) begin
      sy = sy - vtp_pkg::sum_t'(prod.y1);
    end else begin
      sy = sy + vtp_pkg::sum_t'(prod.y1);
    end
    if (cfg.op_mode == vtp_pkg::MODE_ROT_Y) begin
      sz = sz - vtp_pkg::sum_t'(prod.z1);
    end else begin
      sz = sz + vtp_pkg::sum_t'(prod.z1);
    end

    vx_next = vtp_pkg::sum_t'(prod.ax);
    vy_next = vtp_pkg::sum_t'(prod.ay);
    vz_next = vtp_pkg::sum_t'(prod.az);
    case (cfg.op_mode)
      vtp_pkg::MODE_SCALE: begin
        vx_next = vtp_pkg::sum_t'(prod.x0);
        vy_next = vtp_pkg::sum_t'(prod.y0);
        vz_next = vtp_pkg::sum_t'(prod.z0);
      end
      vtp_pkg::MODE_ROT_X: begin
        vy_next = div_trunc(sy);
        vz_next = div_trunc(sz);
      end
      vtp_pkg::MODE_ROT_Y: begin
        vx_next = div_trunc(sx);
        vz_next = div_trunc(sz);
      end
      vtp_pkg::MODE_ROT_Z: begin
        vx_next = div_trunc(sx);
        vy_next = div_trunc(sy);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      vx <= vx_next;
      vy <= vy_next;
      vz <= vz_next;
    end
  end

  // Rotations work relative to the pivot, so it is added back on every axis.
  always_comb begin
    is_rot = cfg.op_mode inside {vtp_pkg::MODE_ROT_X, vtp_pkg::MODE_ROT_Y,
                                 vtp_pkg::MODE_ROT_Z};
    fx = vx;
    fy = vy;
    fz = vz;
    if (is_rot) begin
      fx = vx + vtp_pkg::sum_t'(cfg.vec_x);
      fy = vy + vtp_pkg::sum_t'(cfg.vec_y);
      fz = vz + vtp_pkg::sum_t'(cfg.vec_z);
    end
    cx = vtp_pkg::clamp_coord(fx);
    cy = vtp_pkg::clamp_coord(fy);
    cz = vtp_pkg::clamp_coord(fz);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      xfm.tx  <= cx.val;
      xfm.ty  <= cy.val;
      xfm.tz  <= cz.val;
      xfm.sat <= cx.sat | cy.sat | cz.sat;
    end
  end

endmodule

// ===== hdl/vtp_proj.sv =====
// Cabinet projection stage and output register of the vertex transform unit.
// Depends on vtp_pkg for the transformed vertex, result struct and saturation.
module vtp_proj (
  input  logic              clk,
  input  logic              adv,
  input  vtp_pkg::vtp_xfm_t xfm,
  output vtp_pkg::vtp_out_t result
);

  vtp_pkg::opnd_t      z_adj;
  vtp_pkg::opnd_t      z_half;
  vtp_pkg::vtp_clamp_t cx, cy;

  // Halving rounds toward zero, so negative depths are biased by one first.
  always_comb begin
    z_adj  = vtp_pkg::opnd_t'(xfm.tz) +
             vtp_pkg::opnd_t'({1'b0, xfm.tz[vtp_pkg::COORD_BITS-1]});
    z_half = z_adj >>> 1;
    cx = vtp_pkg::clamp_coord(vtp_pkg::sum_t'(xfm.tx) + vtp_pkg::sum_t'(z_half));
    cy = vtp_pkg::clamp_coord(vtp_pkg::sum_t'(xfm.ty) + vtp_pkg::sum_t'(z_half));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.tx_out    <= xfm.tx;
      result.ty_out    <= xfm.ty;
      result.tz_out    <= xfm.tz;
      result.screen_x  <= cx.val;
      result.screen_y  <= cy.val;
      result.saturated <= xfm.sat | cx.sat | cy.sat;
    end
  end

endmodule

// ===== hdl/vertex_transform_project_unit.sv =====
// Top level of the vertex transform and cabinet projection unit.
// Depends on vtp_pkg, vtp_cfg, vtp_front, vtp_back and vtp_proj.
//
// One vertex request per cycle is accepted and one result leaves per cycle while the output
// is not stalled. A request passes through five pipeline stages: operand offset, 17x16
// products, product sums with scaling, pivot restore with saturation, and projection
// into the output register. Every stage holds its request while the stage after it is
// full and stalled, so the input only stalls once the whole pipeline is full behind a
// stalled output. Configuration registers are written through the plain write port and
// must only change while no request is in flight.
module vertex_transform_project_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [vtp_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [vtp_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  vtp_pkg::vtp_in_t                 vertex,
  output logic                             out_valid,
  input  logic                             out_stall,
  output vtp_pkg::vtp_out_t                result
);

  vtp_pkg::vtp_cfg_t          cfg;
  vtp_pkg::vtp_prod_t         prod;
  vtp_pkg::vtp_xfm_t          xfm;
  logic [vtp_pkg::STAGES:1]   valid;
  logic [vtp_pkg::STAGES+1:1] adv;

  always_comb begin
    adv[vtp_pkg::STAGES+1] = !out_stall;
    for (int k = vtp_pkg::STAGES; k >= 1; k--) begin
      adv[k] = !valid[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[1]) begin
        valid[1] <= in_valid;
      end
      for (int k = 2; k <= vtp_pkg::STAGES; k++) begin
        if (adv[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign in_stall  = !adv[1];
  assign out_valid = valid[vtp_pkg::STAGES];

  vtp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  vtp_front u_front (
    .clk    (clk),
    .adv    (adv[2:1]),
    .cfg    (cfg),
    .vertex (vertex),
    .prod   (prod)
  );

  vtp_back u_back (
    .clk  (clk),
    .adv  (adv[4:3]),
    .cfg  (cfg),
    .prod (prod),
    .xfm  (xfm)
  );

  vtp_proj u_proj (
    .clk    (clk),
    .adv    (adv[5]),
    .xfm    (xfm),
    .result (result)
  );

endmodule

// ===== hdl/vtp_checker.sv =====
// Port-level checker for vertex_transform_project_unit and its bind statement.
// Depends on vtp_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module vtp_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input vtp_pkg::vtp_out_t result
);

  `VTP_ASSERT_RAW(a_reset_empty, clk, rst |=> !out_valid, "output valid after reset")
  `VTP_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(result), "stalled result changed")
  `VTP_ASSERT(a_empty_ready, clk, rst, !out_valid |-> !in_stall, "input stalled with empty output")
  `VTP_ASSERT(a_latency, clk, rst, (in_valid && !in_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall) |=> out_valid, "request lost in pipeline")

endmodule

bind vertex_transform_project_unit vtp_checker u_vtp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .result    (result)
);

// ===== test/vtp_result_checker.sv =====
// Result checker for the vertex transform and projection unit: it mirrors the
// register writes, predicts each accepted vertex request and compares the results.
// Depends on vtp_pkg.
module vtp_result_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [vtp_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [vtp_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  vtp_pkg::vtp_in_t                  vertex,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  vtp_pkg::vtp_out_t                 result,
  output int                                fail_count,
  output int                                outstanding
);
  import vtp_pkg::*;

  localparam longint TRIG_ONE = longint'(1) << TRIG_FRAC_BITS;
  localparam longint COORD_HI = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;

  vtp_cfg_t shadow;
  vtp_out_t predicted_results[$];

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  function automatic longint clip(input longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  function automatic vtp_out_t project_vertex(input vtp_in_t v, input vtp_cfg_t c);
    longint x, y, z, vx, vy, vz, cs, sn;
    longint rx, ry, rz, cx, cy, cz, sx, sy;
    vtp_out_t r;
    x = longint'(v.px);
    y = longint'(v.py);
    z = longint'(v.pz);
    vx = longint'(c.vec_x);
    vy = longint'(c.vec_y);
    vz = longint'(c.vec_z);
    cs = longint'(c.cos_q14);
    sn = longint'(c.sin_q14);
    rx = x;
    ry = y;
    rz = z;
    // Rotations work relative to the pivot; division truncates toward zero.
    case (c.op_mode)
      MODE_TRANSLATE: begin
        rx = x + vx;
        ry = y + vy;
        rz = z + vz;
      end
      MODE_SCALE: begin
        rx = x * vx;
        ry = y * vy;
        rz = z * vz;
      end
      MODE_ROT_X: begin
        ry = ((y - vy) * cs - (z - vz) * sn) / TRIG_ONE + vy;
        rz = ((y - vy) * sn + (z - vz) * cs) / TRIG_ONE + vz;
      end
      MODE_ROT_Y: begin
        rx = ((x - vx) * cs + (z - vz) * sn) / TRIG_ONE + vx;
        rz = ((z - vz) * cs - (x - vx) * sn) / TRIG_ONE + vz;
      end
      MODE_ROT_Z: begin
        rx = ((x - vx) * cs - (y - vy) * sn) / TRIG_ONE + vx;
        ry = ((x - vx) * sn + (y - vy) * cs) / TRIG_ONE + vy;
      end
      default: ;
    endcase
    cx = clip(rx);
    cy = clip(ry);
    cz = clip(rz);
    sx = clip(cx + cz / 2);
    sy = clip(cy + cz / 2);
    r.tx_out = coord_t'(cx);
    r.ty_out = coord_t'(cy);
    r.tz_out = coord_t'(cz);
    r.screen_x = coord_t'(sx);
    r.screen_y = coord_t'(sy);
    r.saturated = (cx != rx) || (cy != ry) || (cz != rz) ||
                  (sx != cx + cz / 2) || (sy != cy + cz / 2);
    return r;
  endfunction

  task automatic report_field(input string field, input logic signed [31:0] want,
                              input logic signed [31:0] got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin : watch
    vtp_out_t want;
    bit bad;
    int fails;
    fails = 0;
    if (rst) begin
      shadow.op_mode = MODE_TRANSLATE;
      shadow.vec_x = '0;
      shadow.vec_y = '0;
      shadow.vec_z = '0;
      shadow.cos_q14 = COS_RESET;
      shadow.sin_q14 = '0;
      predicted_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result %h arrived with no request outstanding", $time, result);
          fails++;
        end else begin
          want = predicted_results.pop_front();
          bad = 1'b0;
          if (result.tx_out !== want.tx_out) begin
            report_field("tx_out", 32'(want.tx_out), 32'(result.tx_out));
            bad = 1'b1;
          end
          if (result.ty_out !== want.ty_out) begin
            report_field("ty_out", 32'(want.ty_out), 32'(result.ty_out));
            bad = 1'b1;
          end
          if (result.tz_out !== want.tz_out) begin
            report_field("tz_out", 32'(want.tz_out), 32'(result.tz_out));
            bad = 1'b1;
          end
          if (result.screen_x !== want.screen_x) begin
            report_field("screen_x", 32'(want.screen_x), 32'(result.screen_x));
            bad = 1'b1;
          end
          if (result.screen_y !== want.screen_y) begin
            report_field("screen_y", 32'(want.screen_y), 32'(result.screen_y));
            bad = 1'b1;
          end
          if (result.saturated !== want.saturated) begin
            report_field("saturated", 32'(want.saturated), 32'(result.saturated));
            bad = 1'b1;
          end
          if (bad) fails++;
        end
      end
      if (in_valid && !in_stall) predicted_results.push_back(project_vertex(vertex, shadow));
      if (cfg_we) begin
        case (cfg_idx)
          REG_OP_MODE: shadow.op_mode = cfg_data[MODE_BITS-1:0];
          REG_VEC_X:   shadow.vec_x = cfg_data[COORD_BITS-1:0];
          REG_VEC_Y:   shadow.vec_y = cfg_data[COORD_BITS-1:0];
          REG_VEC_Z:   shadow.vec_z = cfg_data[COORD_BITS-1:0];
          REG_COS:     shadow.cos_q14 = cfg_data[TRIG_BITS-1:0];
          REG_SIN:     shadow.sin_q14 = cfg_data[TRIG_BITS-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= predicted_results.size();
    fail_count <= fail_count + fails;
  end

endmodule

// ===== test/tb_vertex_transform_project_unit.sv =====
// Testbench top for the vertex transform and projection unit: it drives register
// settings and vertex requests with random idling on both channels and gives the verdict.
// Depends on vtp_pkg, vertex_transform_project_unit and vtp_result_checker.
module tb_vertex_transform_project_unit;
  import vtp_pkg::*;

  localparam int RANDOM_ITEMS = 700;
  localparam int CALM_ITEMS   = 60;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TRIG_ONE     = 2 ** TRIG_FRAC_BITS;
  localparam int TRIG_DIAG    = 11585;

  localparam coord_t COORD_MAX = coord_t'(2 ** (COORD_BITS - 1) - 1);
  localparam coord_t COORD_MIN = ~COORD_MAX;
  localparam trig_t  TRIG_MAX  = trig_t'(2 ** (TRIG_BITS - 1) - 1);
  localparam trig_t  TRIG_MIN  = ~TRIG_MAX;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  vtp_in_t                  vertex;
  logic                     out_valid;
  logic                     out_stall;
  vtp_out_t                 result;
  int                       fail_count;
  int                       outstanding;

  bit calm;
  bit gapless;
  bit hold_req;
  bit drain_timeout;
  int vertices_sent;
  int settings_loaded;
  int random_start;
  int guard;
  int spare;

  vertex_transform_project_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .vertex    (vertex),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  vtp_result_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .vertex      (vertex),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result      (result),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  // The output side stalls in random bursts, and once holds off for a long stretch.
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  function automatic coord_t corner_coord();
    case ($urandom_range(0, 4))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return coord_t'(0);
      3: return coord_t'(-1);
      default: return coord_t'(1);
    endcase
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return corner_coord();
      1, 2, 3, 4: return coord_t'($urandom);
      default: return coord_t'($urandom_range(0, 2000) - 1000);
    endcase
  endfunction

  function automatic vtp_in_t make_vertex(input bit corners);
    vtp_in_t v;
    v.px = corners ? corner_coord() : rand_coord();
    v.py = corners ? corner_coord() : rand_coord();
    v.pz = corners ? corner_coord() : rand_coord();
    return v;
  endfunction

  function automatic vtp_cfg_t make_setting(input logic [MODE_BITS-1:0] mode,
                                            input coord_t vx, input coord_t vy,
                                            input coord_t vz, input trig_t cs,
                                            input trig_t sn);
    vtp_cfg_t s;
    s.op_mode = mode;
    s.vec_x = vx;
    s.vec_y = vy;
    s.vec_z = vz;
    s.cos_q14 = cs;
    s.sin_q14 = sn;
    return s;
  endfunction

  function automatic vtp_cfg_t random_setting();
    vtp_cfg_t s;
    int pick;
    pick = $urandom_range(0, 11);
    if (pick < 10) s.op_mode = MODE_BITS'(pick / 2);
    else s.op_mode = MODE_BITS'(int'(MODE_ROT_Z) + $urandom_range(1, 3));
    // Small scale factors keep most scaled vertices inside the coordinate range.
    if (s.op_mode == MODE_SCALE && $urandom_range(0, 3) != 0) begin
      s.vec_x = coord_t'($urandom_range(0, 16) - 8);
      s.vec_y = coord_t'($urandom_range(0, 16) - 8);
      s.vec_z = coord_t'($urandom_range(0, 16) - 8);
    end else begin
      s.vec_x = rand_coord();
      s.vec_y = rand_coord();
      s.vec_z = rand_coord();
    end
    if ($urandom_range(0, 3) != 0) begin
      s.cos_q14 = trig_t'($urandom_range(0, 2 * TRIG_ONE) - TRIG_ONE);
      s.sin_q14 = trig_t'($urandom_range(0, 2 * TRIG_ONE) - TRIG_ONE);
    end else begin
      s.cos_q14 = trig_t'($urandom);
      s.sin_q14 = trig_t'($urandom);
    end
    return s;
  endfunction

  task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx,
                         input logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic load_setting(input vtp_cfg_t s);
    put_reg(REG_OP_MODE, CFG_DATA_BITS'(s.op_mode));
    put_reg(REG_VEC_X, s.vec_x);
    put_reg(REG_VEC_Y, s.vec_y);
    put_reg(REG_VEC_Z, s.vec_z);
    put_reg(REG_COS, s.cos_q14);
    put_reg(REG_SIN, s.sin_q14);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  task automatic offer_vertex(input vtp_in_t v);
    in_valid <= 1'b1;
    vertex <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    vertices_sent++;
  endtask

  task automatic send_batch(input int count, input bit corners);
    for (int i = 0; i < count; i++) begin
      if (!calm && !gapless && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      offer_vertex(make_vertex(corners));
    end
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic run_phase(input vtp_cfg_t s, input int count, input bit corners);
    load_setting(s);
    send_batch(count, corners);
    settle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    vertex = '0;
    calm = 1'b0;
    gapless = 1'b0;
    hold_req = 1'b0;
    drain_timeout = 1'b0;
    vertices_sent = 0;
    settings_loaded = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The reset values of the registers are used first.
    send_batch(4, 1'b1);
    settle();
    run_phase(make_setting(MODE_TRANSLATE, COORD_MAX, COORD_MIN, coord_t'(1),
                           trig_t'(0), trig_t'(0)), 3, 1'b1);
    run_phase(make_setting(MODE_SCALE, COORD_MIN, COORD_MAX, coord_t'(-1),
                           trig_t'(0), trig_t'(0)), 3, 1'b1);
    run_phase(make_setting(MODE_ROT_X, coord_t'(100), coord_t'(-200), coord_t'(300),
                           trig_t'(0), trig_t'(TRIG_ONE)), 2, 1'b1);
    run_phase(make_setting(MODE_ROT_Y, COORD_MAX, COORD_MIN, COORD_MAX,
                           trig_t'(-TRIG_ONE), trig_t'(0)), 2, 1'b1);
    run_phase(make_setting(MODE_ROT_Z, coord_t'(0), coord_t'(0), coord_t'(0),
                           trig_t'(TRIG_DIAG), trig_t'(TRIG_DIAG)), 2, 1'b1);
    // Trig values beyond one are used as given.
    run_phase(make_setting(MODE_ROT_Z, COORD_MIN, COORD_MAX, coord_t'(0),
                           TRIG_MIN, TRIG_MAX), 2, 1'b1);
    // Spare modes pass the vertex through and still project it.
    for (spare = int'(MODE_ROT_Z) + 1; spare < 2 ** MODE_BITS; spare++) begin
      run_phase(make_setting(MODE_BITS'(spare), COORD_MAX, COORD_MIN, COORD_MAX,
                             TRIG_MAX, TRIG_MIN), 1, 1'b1);
    end

    random_start = vertices_sent;
    gapless = 1'b1;
    hold_req = 1'b1;
    run_phase(random_setting(), 40, 1'b0);
    gapless = 1'b0;
    while (vertices_sent - random_start < RANDOM_ITEMS - CALM_ITEMS) begin
      run_phase(random_setting(), $urandom_range(15, 50), 1'b0);
    end
    calm = 1'b1;
    load_setting(random_setting());
    send_batch(CALM_ITEMS, 1'b0);

    guard = 0;
    while (outstanding != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    drain_timeout = (outstanding != 0);
    repeat (STAGES + 3) @(posedge clk);

    $display("Ran %0d vertex requests under %0d register settings, covering every operation",
             vertices_sent, settings_loaded);
    $display("and spare mode, corner values, saturation, odd trig values and a long output hold.");
    if (fail_count == 0 && !drain_timeout) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/vtp_pkg.sv
hdl/vtp_cfg.sv
hdl/vtp_front.sv
hdl/vtp_back.sv
hdl/vtp_proj.sv
hdl/vertex_transform_project_unit.sv
hdl/vtp_checker.sv
test/vtp_result_checker.sv
test/tb_vertex_transform_project_unit.sv
